### src/jsu_pkg.sv
// ----------------------------------------------------------------------------
// jsu_pkg: shared types and constants for the JSON string unescaper
// Request structs, the decode-to-emit command, character codes and the
// UTF-8 encoder used by the front end.
// ----------------------------------------------------------------------------
package jsu_pkg;

	// Input request: one raw literal byte or the end marker
	typedef struct packed {
		logic       kind;
		logic [7:0] in_byte;
	} jsu_item_t;

	// Result request: one output byte or the terminator
	typedef struct packed {
		logic [7:0] out_byte;
		logic       is_end;
		logic       status;
	} jsu_result_t;

	// Command queued between the decoder and the byte emitter
	localparam int unsigned CMD_MAX_BYTES = 4;
	localparam int unsigned CMD_BCNT_W    = $clog2(CMD_MAX_BYTES + 1);
	localparam int unsigned CMD_IDX_W     = $clog2(CMD_MAX_BYTES);

	typedef struct packed {
		logic [CMD_BCNT_W-1:0]              cnt;
		logic [CMD_MAX_BYTES-1:0][7:0]      bytes;
		logic                               is_end;
		logic                               status;
	} jsu_cmd_t;

	localparam int unsigned CMD_DEPTH = 4;
	localparam int unsigned CMD_PTR_W = $clog2(CMD_DEPTH);
	localparam int unsigned CMD_CNT_W = $clog2(CMD_DEPTH + 1);

	// Decoder modes, one-hot
	typedef enum logic [5:0] {
		M_TEXT    = 6'b000001,
		M_ESC     = 6'b000010,
		M_HEX_HI  = 6'b000100,
		M_WANT_BS = 6'b001000,
		M_WANT_U  = 6'b010000,
		M_HEX_LO  = 6'b100000
	} jsu_mode_t;

	// Character codes
	localparam logic [7:0] CH_BSLASH = 8'h5C;
	localparam logic [7:0] CH_QUOTE  = 8'h22;
	localparam logic [7:0] CH_SLASH  = 8'h2F;
	localparam logic [7:0] CH_B      = 8'h62;
	localparam logic [7:0] CH_F      = 8'h66;
	localparam logic [7:0] CH_N      = 8'h6E;
	localparam logic [7:0] CH_R      = 8'h72;
	localparam logic [7:0] CH_T      = 8'h74;
	localparam logic [7:0] CH_U      = 8'h75;

	localparam logic [7:0] CTL_BS  = 8'h08;
	localparam logic [7:0] CTL_FF  = 8'h0C;
	localparam logic [7:0] CTL_LF  = 8'h0A;
	localparam logic [7:0] CTL_CR  = 8'h0D;
	localparam logic [7:0] CTL_TAB = 8'h09;

	// Surrogate ranges, by the top six bits
	localparam logic [5:0] SURR_HIGH_TAG = 6'b110110; // D800..DBFF
	localparam logic [5:0] SURR_LOW_TAG  = 6'b110111; // DC00..DFFF
	localparam logic [20:0] SUPP_BASE    = 21'h10000;

	typedef struct packed {
		logic       ok;
		logic [3:0] value;
	} jsu_hex_t;

	function automatic jsu_hex_t hex_digit(input logic [7:0] c);
		jsu_hex_t h;
		h = '0;
		if (c >= 8'h30 && c <= 8'h39) begin
			h.ok    = 1'b1;
			h.value = 4'(c - 8'h30);
		end else if (c >= 8'h41 && c <= 8'h46) begin
			h.ok    = 1'b1;
			h.value = 4'(c - 8'h37);
		end else if (c >= 8'h61 && c <= 8'h66) begin
			h.ok    = 1'b1;
			h.value = 4'(c - 8'h57);
		end
		return h;
	endfunction

	// Code point to one..four UTF-8 bytes, first byte in lane 0
	function automatic jsu_cmd_t utf8_enc(input logic [20:0] cp);
		jsu_cmd_t c;
		c = '0;
		if (cp < 21'h80) begin
			c.cnt      = CMD_BCNT_W'(1);
			c.bytes[0] = cp[7:0];
		end else if (cp < 21'h800) begin
			c.cnt      = CMD_BCNT_W'(2);
			c.bytes[0] = {3'b110, cp[10:6]};
			c.bytes[1] = {2'b10, cp[5:0]};
		end else if (cp < 21'h10000) begin
			c.cnt      = CMD_BCNT_W'(3);
			c.bytes[0] = {4'b1110, cp[15:12]};
			c.bytes[1] = {2'b10, cp[11:6]};
			c.bytes[2] = {2'b10, cp[5:0]};
		end else begin
			c.cnt      = CMD_BCNT_W'(4);
			c.bytes[0] = {5'b11110, cp[20:18]};
			c.bytes[1] = {2'b10, cp[17:12]};
			c.bytes[2] = {2'b10, cp[11:6]};
			c.bytes[3] = {2'b10, cp[5:0]};
		end
		return c;
	endfunction

endpackage

### src/jsu_front.sv
// ----------------------------------------------------------------------------
// jsu_front: escape decoder
// Takes one raw byte per cycle unless stalled, tracks the escape state and
// issues a command (up to four bytes, or the terminator) to the command queue.
// ----------------------------------------------------------------------------
module jsu_front
	import jsu_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      accept,
	input  jsu_item_t item,
	output logic      cmd_valid,
	output jsu_cmd_t  cmd
);

	jsu_mode_t   mode_q, mode_d;
	logic [1:0]  cnt_q, cnt_d;
	logic [11:0] acc_q, acc_d;   // first three digits; the fourth arrives live
	logic [9:0]  high_q, high_d;
	logic        err_q, err_d;

	jsu_hex_t    hex;
	logic [15:0] word;
	logic [20:0] cp_pair;
	logic        fail;

	always_comb begin
		mode_d    = mode_q;
		cnt_d     = cnt_q;
		acc_d     = acc_q;
		high_d    = high_q;
		err_d     = err_q;
		cmd_valid = 1'b0;
		cmd       = '0;
		fail      = 1'b0;
		hex       = hex_digit(item.in_byte);
		word      = {acc_q, hex.value};
		cp_pair   = SUPP_BASE + {1'b0, high_q, word[9:0]};

		if (accept) begin
			if (item.kind) begin
				cmd_valid  = 1'b1;
				cmd.cnt    = CMD_BCNT_W'(1);
				cmd.is_end = 1'b1;
				cmd.status = err_q | (mode_q != M_TEXT);
				mode_d     = M_TEXT;
				cnt_d      = '0;
				acc_d      = '0;
				high_d     = '0;
				err_d      = 1'b0;
			end else if (!err_q) begin
				case (mode_q)
					M_TEXT: begin
						if (item.in_byte == CH_BSLASH) begin
							mode_d = M_ESC;
						end else begin
							cmd_valid    = 1'b1;
							cmd.cnt      = CMD_BCNT_W'(1);
							cmd.bytes[0] = item.in_byte;
						end
					end
					M_ESC: begin
						mode_d       = M_TEXT;
						cmd.cnt      = CMD_BCNT_W'(1);
						cmd_valid    = 1'b1;
						case (item.in_byte)
							CH_B:      cmd.bytes[0] = CTL_BS;
							CH_F:      cmd.bytes[0] = CTL_FF;
							CH_N:      cmd.bytes[0] = CTL_LF;
							CH_R:      cmd.bytes[0] = CTL_CR;
							CH_T:      cmd.bytes[0] = CTL_TAB;
							CH_QUOTE,
							CH_BSLASH,
							CH_SLASH:  cmd.bytes[0] = item.in_byte;
							CH_U: begin
								cmd_valid = 1'b0;
								mode_d    = M_HEX_HI;
								cnt_d     = '0;
								acc_d     = '0;
							end
							default: begin
								cmd_valid = 1'b0;
								fail      = 1'b1;
							end
						endcase
					end
					M_HEX_HI, M_HEX_LO: begin
						if (!hex.ok) begin
							fail = 1'b1;
						end else if (cnt_q != 2'd3) begin
							cnt_d = 2'(cnt_q + 2'd1);
							acc_d = word[11:0];
						end else begin
							cnt_d = '0;
							acc_d = '0;
							if (mode_q == M_HEX_LO) begin
								if (word[15:10] != SURR_LOW_TAG) begin
									fail = 1'b1;
								end else begin
									cmd_valid = 1'b1;
									cmd       = utf8_enc(cp_pair);
									high_d    = '0;
									mode_d    = M_TEXT;
								end
							end else if (word[15:10] == SURR_LOW_TAG || word == 16'h0) begin
								fail = 1'b1;
							end else if (word[15:10] == SURR_HIGH_TAG) begin
								high_d = word[9:0];
								mode_d = M_WANT_BS;
							end else begin
								cmd_valid = 1'b1;
								cmd       = utf8_enc({5'b0, word});
								mode_d    = M_TEXT;
							end
						end
					end
					M_WANT_BS: begin
						if (item.in_byte != CH_BSLASH) begin
							fail = 1'b1;
						end else begin
							mode_d = M_WANT_U;
						end
					end
					M_WANT_U: begin
						if (item.in_byte != CH_U) begin
							fail = 1'b1;
						end else begin
							mode_d = M_HEX_LO;
							cnt_d  = '0;
							acc_d  = '0;
						end
					end
					default: fail = 1'b1;
				endcase
				if (fail) begin
					err_d  = 1'b1;
					mode_d = M_TEXT;
					cnt_d  = '0;
					acc_d  = '0;
					high_d = '0;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= M_TEXT;
			cnt_q  <= '0;
			acc_q  <= '0;
			high_q <= '0;
			err_q  <= 1'b0;
		end else begin
			mode_q <= mode_d;
			cnt_q  <= cnt_d;
			acc_q  <= acc_d;
			high_q <= high_d;
			err_q  <= err_d;
		end
	end

endmodule

### src/jsu_cmd_fifo.sv
// ----------------------------------------------------------------------------
// jsu_cmd_fifo: command queue
// Small register queue decoupling the decoder from the byte emitter.
// ----------------------------------------------------------------------------
module jsu_cmd_fifo
	import jsu_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     wr,
	input  jsu_cmd_t wr_data,
	input  logic     rd,
	output jsu_cmd_t rd_data,
	output logic     empty,
	output logic     full
);

	jsu_cmd_t               mem_q [CMD_DEPTH];
	logic [CMD_PTR_W-1:0]   wr_ptr_q;
	logic [CMD_PTR_W-1:0]   rd_ptr_q;
	logic [CMD_CNT_W-1:0]   count_q;

	assign empty   = (count_q == '0);
	assign full    = (count_q == CMD_CNT_W'(CMD_DEPTH));
	assign rd_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (wr) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (wr) begin
				wr_ptr_q <= CMD_PTR_W'(wr_ptr_q + 1'b1);
			end
			if (rd) begin
				rd_ptr_q <= CMD_PTR_W'(rd_ptr_q + 1'b1);
			end
			case ({wr, rd})
				2'b10:   count_q <= CMD_CNT_W'(count_q + 1'b1);
				2'b01:   count_q <= CMD_CNT_W'(count_q - 1'b1);
				default: count_q <= count_q;
			endcase
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(wr && full && !rd))
		else $error("command queue written while full");

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CMD_CNT_W'(CMD_DEPTH))
		else $error("command queue count out of range");

endmodule

### src/jsu_back.sv
// ----------------------------------------------------------------------------
// jsu_back: byte emitter
// Walks the head command into the output reg, one byte per cycle unless held.
// ----------------------------------------------------------------------------
module jsu_back
	import jsu_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  jsu_cmd_t    head,
	input  logic        head_valid,
	output logic        head_rd,
	input  logic        pop,
	output jsu_result_t result,
	output logic        empty
);

	logic [CMD_IDX_W-1:0] idx_q;
	logic                 out_v_q;
	jsu_result_t          out_q;
	logic                 load;
	logic                 last;

	assign load    = head_valid && (!out_v_q || pop);
	assign last    = (CMD_BCNT_W'(idx_q) + CMD_BCNT_W'(1)) == head.cnt;
	assign head_rd = load && last;
	assign empty   = !out_v_q;
	assign result  = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q   <= '0;
			out_v_q <= 1'b0;
		end else begin
			out_v_q <= load || (out_v_q && !pop);
			if (load) begin
				idx_q <= last ? '0 : CMD_IDX_W'(idx_q + 1'b1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			out_q.out_byte <= head.bytes[idx_q];
			out_q.is_end   <= head.is_end;
			out_q.status   <= head.status;
		end
	end

	a_idx_in_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		head_valid |-> (CMD_BCNT_W'(idx_q) < head.cnt))
		else $error("byte index beyond head command");

	a_idx_rests_zero: assert property (@(posedge clk) disable iff (!arst_n)
		!head_valid |-> idx_q == '0)
		else $error("byte index left mid-command with queue empty");

	a_pop_needs_data: assert property (@(posedge clk) disable iff (!arst_n)
		head_rd |-> head_valid)
		else $error("command retired from empty queue");

endmodule

### src/json_string_unescape_utf8_unit.sv
// An accepted request goes into the command queue, then into the emitter's
// output register. Throughput: one input request per cycle unless the command
// queue is full; one result byte per cycle while results are popped, so a
// code point of four UTF-8 bytes holds the emitter while the four-entry
// command queue keeps the decoder taking input.
// Reset (arst_n low, asynchronous): text mode, no error, queue and output empty.
// ----------------------------------------------------------------------------
// json_string_unescape_utf8_unit: streaming JSON string unescaper
// Raw bytes of a JSON string literal in, unescaped UTF-8 bytes out, closed by
// a NUL terminator carrying the ok / error status.
// ----------------------------------------------------------------------------
module json_string_unescape_utf8_unit
	import jsu_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	// input request queue side
	input  logic        push,
	output logic        full,
	input  jsu_item_t   item,
	// result queue side
	output logic        empty,
	input  logic        pop,
	output jsu_result_t result
);

	// Decoder to queue
	logic     accept;
	logic     cmd_valid;
	jsu_cmd_t cmd;

	// Queue to emitter
	jsu_cmd_t head;
	logic     head_empty;
	logic     head_rd;

	// The decoder stalls only when the command queue is full. Each input
	// request yields at most one command, so a free slot always suffices.
	assign accept = push && !full;

	jsu_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.accept    (accept),
		.item      (item),
		.cmd_valid (cmd_valid),
		.cmd       (cmd)
	);

	// Commands: plain bytes and simple escapes are one byte, \u escapes one
	// to four, the end request a single terminator.
	jsu_cmd_fifo u_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr      (cmd_valid),
		.wr_data (cmd),
		.rd      (head_rd),
		.rd_data (head),
		.empty   (head_empty),
		.full    (full)
	);

	// The emitter's output register parts the result side from the queue,
	// so a waiting result does not block decoding until the command queue fills.
	jsu_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head       (head),
		.head_valid (!head_empty),
		.head_rd    (head_rd),
		.pop        (pop),
		.result     (result),
		.empty      (empty)
	);

endmodule
